// ===== rtl/single_wire_sensor_byte_reader_macros.svh =====
// Assertion macros for the checker file of the sensor byte reader.
`ifndef SINGLE_WIRE_SENSOR_BYTE_READER_MACROS_SVH
`define SINGLE_WIRE_SENSOR_BYTE_READER_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while reset is active.
`define SWSBR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and ignored while reset is active.
`define SWSBR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/swsbr_pkg.sv =====
package swsbr_pkg;

	localparam int unsigned BITS_PER_READ = 8;
	localparam int unsigned CNT_W = 12;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_WAIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_CHK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_SAMPLE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_TIMEOUT  = 3'd5;

	localparam logic [CNT_W-1:0] RST_START_LOW     = 12'd1300;
	localparam logic [CNT_W-1:0] RST_START_HIGH    = 12'd30;
	localparam logic [CNT_W-1:0] RST_RESPONSE_WAIT = 12'd40;
	localparam logic [CNT_W-1:0] RST_RESPONSE_CHK  = 12'd80;
	localparam logic [CNT_W-1:0] RST_BIT_SAMPLE    = 12'd40;
	localparam logic [CNT_W-1:0] RST_EDGE_TIMEOUT  = 12'd2000;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_DRIVE_LOW  = 4'd1,
		PH_DRIVE_HIGH = 4'd2,
		PH_RESP_WAIT  = 4'd3,
		PH_RESP_CHECK = 4'd4,
		PH_RESP_FALL  = 4'd5,
		PH_BIT_RISE   = 4'd6,
		PH_BIT_SAMPLE = 4'd7,
		PH_BIT_FALL   = 4'd8
	} phase_t;

	typedef struct packed {
		logic [1:0] operation;
		logic       line_level;
	} in_item_t;

	typedef struct packed {
		logic       drive_enable;
		logic       drive_level;
		logic       busy_res;
		logic       done_res;
		logic       response_ok;
		logic [7:0] data_byte;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] start_low_us;
		logic [CNT_W-1:0] start_high_us;
		logic [CNT_W-1:0] response_wait_us;
		logic [CNT_W-1:0] response_check_us;
		logic [CNT_W-1:0] bit_sample_us;
		logic [CNT_W-1:0] edge_timeout_us;
	} cfg_regs_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] tick_cnt;
		logic [IDX_W-1:0] bit_idx;
		logic [7:0]       shift_byte;
		logic             resp_flag;
	} link_state_t;

endpackage

// ===== rtl/swsbr_cfg_regs.sv =====
module swsbr_cfg_regs import swsbr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CNT_W-1:0]     wr_data,
	output cfg_regs_t            regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_low_us      <= RST_START_LOW;
			regs_q.start_high_us     <= RST_START_HIGH;
			regs_q.response_wait_us  <= RST_RESPONSE_WAIT;
			regs_q.response_check_us <= RST_RESPONSE_CHK;
			regs_q.bit_sample_us     <= RST_BIT_SAMPLE;
			regs_q.edge_timeout_us   <= RST_EDGE_TIMEOUT;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_LOW:     regs_q.start_low_us      <= wr_data;
				REG_START_HIGH:    regs_q.start_high_us     <= wr_data;
				REG_RESPONSE_WAIT: regs_q.response_wait_us  <= wr_data;
				REG_RESPONSE_CHK:  regs_q.response_check_us <= wr_data;
				REG_BIT_SAMPLE:    regs_q.bit_sample_us     <= wr_data;
				REG_EDGE_TIMEOUT:  regs_q.edge_timeout_us   <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== rtl/swsbr_step.sv =====
module swsbr_step import swsbr_pkg::*; (
	input  link_state_t cur,
	input  in_item_t    item,
	input  cfg_regs_t   regs,
	output link_state_t nxt,
	output out_item_t   result
);

	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] limit;
	logic             reached;
	logic [IDX_W:0]   idx_inc;
	logic             done;

	assign cnt_inc = cur.tick_cnt + 1'b1;
	assign idx_inc = {1'b0, cur.bit_idx} + 1'b1;

	// Only one timed phase is active at a time, so a single comparator serves all.
	always_comb begin
		case (cur.phase)
			PH_DRIVE_LOW:  limit = regs.start_low_us;
			PH_DRIVE_HIGH: limit = regs.start_high_us;
			PH_RESP_WAIT:  limit = regs.response_wait_us;
			PH_RESP_CHECK: limit = regs.response_check_us;
			PH_BIT_SAMPLE: limit = regs.bit_sample_us;
			default:       limit = regs.edge_timeout_us;
		endcase
	end

	assign reached = (cnt_inc >= limit);

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		case (cur.phase)
			PH_IDLE: begin
				if (item.operation == OP_START) begin
					nxt.resp_flag = 1'b0;
					nxt.phase     = PH_DRIVE_LOW;
					nxt.tick_cnt  = '0;
				end else if (item.operation == OP_READ) begin
					nxt.bit_idx    = '0;
					nxt.shift_byte = '0;
					nxt.phase      = PH_BIT_RISE;
					nxt.tick_cnt   = '0;
				end
			end
			PH_DRIVE_LOW, PH_DRIVE_HIGH, PH_RESP_WAIT, PH_RESP_CHECK: begin
				nxt.tick_cnt = cnt_inc;
				if (reached) begin
					nxt.tick_cnt = '0;
					case (cur.phase)
						PH_DRIVE_LOW:  nxt.phase = PH_DRIVE_HIGH;
						PH_DRIVE_HIGH: nxt.phase = PH_RESP_WAIT;
						PH_RESP_WAIT: begin
							nxt.phase = item.line_level ? PH_RESP_FALL : PH_RESP_CHECK;
						end
						default: begin
							if (item.line_level) begin
								nxt.resp_flag = 1'b1;
							end
							nxt.phase = PH_RESP_FALL;
						end
					endcase
				end
			end
			PH_RESP_FALL: begin
				nxt.tick_cnt = cnt_inc;
				if (!item.line_level || reached) begin
					nxt.phase    = PH_IDLE;
					nxt.tick_cnt = '0;
					done         = 1'b1;
				end
			end
			PH_BIT_RISE: begin
				nxt.tick_cnt = cnt_inc;
				if (item.line_level || reached) begin
					nxt.phase    = PH_BIT_SAMPLE;
					nxt.tick_cnt = '0;
				end
			end
			PH_BIT_SAMPLE: begin
				nxt.tick_cnt = cnt_inc;
				if (reached) begin
					nxt.shift_byte = {cur.shift_byte[6:0], item.line_level};
					nxt.phase      = PH_BIT_FALL;
					nxt.tick_cnt   = '0;
				end
			end
			PH_BIT_FALL: begin
				nxt.tick_cnt = cnt_inc;
				if (!item.line_level || reached) begin
					nxt.tick_cnt = '0;
					if (idx_inc >= (IDX_W+1)'(BITS_PER_READ)) begin
						nxt.bit_idx = '0;
						nxt.phase   = PH_IDLE;
						done        = 1'b1;
					end else begin
						nxt.bit_idx = idx_inc[IDX_W-1:0];
						nxt.phase   = PH_BIT_RISE;
					end
				end
			end
			default: begin
				nxt.phase    = PH_IDLE;
				nxt.tick_cnt = '0;
			end
		endcase
	end

	always_comb begin
		result.drive_enable = (nxt.phase == PH_DRIVE_LOW) || (nxt.phase == PH_DRIVE_HIGH);
		result.drive_level  = (nxt.phase == PH_DRIVE_HIGH);
		result.busy_res     = (nxt.phase != PH_IDLE);
		result.done_res     = done;
		result.response_ok  = nxt.resp_flag;
		result.data_byte    = nxt.shift_byte;
	end

endmodule

// ===== rtl/single_wire_sensor_byte_reader.sv =====
// Master side of a single-wire humidity sensor link. Each input beat is one
// microsecond tick carrying an operation code and the sampled line level;
// each input beat produces exactly one output beat with the line drive
// controls, the busy and done flags, the sensor response flag and the shift
// byte. The block takes one beat per clock cycle when the output side is not
// stalled: a beat is held in the input register, then the step logic
// updates the link state and loads the output register, which presents the
// result on the output. Throughput is set only by the output register; the
// input stalls only while a finished result is held there and the input
// register is occupied. Configuration writes are always ready and take effect
// at once; they should only be issued while no beat is in flight.
module single_wire_sensor_byte_reader import swsbr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	cfg_regs_t   regs;
	link_state_t state_q;
	link_state_t state_next;
	out_item_t   step_result;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        out_valid_q;
	out_item_t   out_item_q;
	logic        advance;

	// The register file never pushes back.
	assign cfg_ready = 1'b1;

	swsbr_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs)
	);

	// The output register can take a new result when it is empty or being drained.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

	swsbr_step u_step (
		.cur    (state_q),
		.item   (item_s1),
		.regs   (regs),
		.nxt    (state_next),
		.result (step_result)
	);

	// The link state moves only when a beat leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.tick_cnt   <= '0;
			state_q.bit_idx    <= '0;
			state_q.shift_byte <= '0;
			state_q.resp_flag  <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_item_q <= step_result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== rtl/swsbr_checker.sv =====
`include "single_wire_sensor_byte_reader_macros.svh"

module swsbr_checker import swsbr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// A stalled input beat stays put.
	`SWSBR_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
		in_valid && $stable(in_item), "input beat changed while stalled")

	// A stalled result beat must stay put.
	`SWSBR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_item), "output beat changed while stalled")

	// The input only backs up behind a held result.
	`SWSBR_ASSERT_NOW(a_stall_cause, in_stall,
		out_valid && out_stall, "input stalled with free output register")

	// Driving the line belongs to a running start sequence.
	`SWSBR_ASSERT_NOW(a_drive_busy, out_valid && out_item.drive_enable,
		out_item.busy_res, "line driven while not busy")

	// An operation that finishes leaves the block idle and the line released.
	`SWSBR_ASSERT_NOW(a_done_idle, out_valid && out_item.done_res,
		!out_item.busy_res && !out_item.drive_enable, "done with block still busy")

endmodule

bind single_wire_sensor_byte_reader swsbr_checker u_swsbr_checker (.*);
